[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge, disabled while reset is high.
`define CHK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assert a property on the rising clock edge, including during reset.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/hvd_pkg.sv]
// ----------------------------------------------------------------------------
// hvd_pkg
// Shared constants, types and tables for the haversine distance pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package hvd_pkg;

  localparam int LatW = 28;
  localparam int LonW = 29;
  localparam int RadW = 23;
  localparam int DistW = 25;
  localparam int DefaultStages = 24;
  localparam logic [RadW-1:0] RadiusReset = 23'd6371000;

  // Angle and CORDIC datapath width: Q30 plus sign and headroom.
  localparam int AngW = 34;
  // Root and vectoring datapath width.
  localparam int RootW = 32;
  localparam int VecW = 34;

  localparam logic [28:0] FullTurn = 29'd360000000;
  localparam logic [27:0] HalfTurn = 28'd180000000;
  localparam logic [27:0] QuarterTurn = 28'd90000000;
  localparam logic [31:0] UdegRadQ54 = 32'd314410567;
  localparam logic signed [AngW-1:0] GainQ30 = 34'sd652032874;

  function automatic logic signed [AngW-1:0] atan_q30(input int idx);
    logic [29:0] v;
    case (idx)
      0: v = 30'd843314857;
      1: v = 30'd497837829;
      2: v = 30'd263043837;
      3: v = 30'd133525159;
      4: v = 30'd67021687;
      5: v = 30'd33543516;
      6: v = 30'd16775851;
      7: v = 30'd8388437;
      8: v = 30'd4194283;
      9: v = 30'd2097149;
      default: v = (idx >= 10 && idx <= 30) ? (30'd1 << (30 - idx)) : 30'd0;
    endcase
    return $signed({4'b0000, v});
  endfunction

  // Reduce a microdegree difference (|d| < 2 full turns) to [0, 180 deg].
  function automatic logic [27:0] fold_turn(input logic signed [29:0] d);
    logic signed [30:0] r;
    logic signed [30:0] full;
    full = $signed({2'b00, FullTurn});
    r = 31'(d);
    if (r < 0) r = r + full;
    if (r < 0) r = r + full;
    if (r >= full) r = r - full;
    if (r > $signed({3'b000, HalfTurn})) r = full - r;
    return r[27:0];
  endfunction

  typedef struct packed {
    logic signed [AngW-1:0] x;
    logic signed [AngW-1:0] y;
    logic signed [AngW-1:0] z;
  } rot_t;

  typedef struct packed {
    logic [61:0] rem;
    logic [61:0] res;
    logic [61:0] v;
  } root_t;

endpackage
`default_nettype wire

[rtl/haversine_distance.sv]
// Throughput: one transfer per cycle unless the output stalls; each stage is one cell of a pipeline.
// The pipeline advances whenever the output register is empty or taken.
// Reset clears valid flags and loads the radius with 6371000.
// ----------------------------------------------------------------------------
// haversine_distance
// Great-circle distance by the haversine formula on chains of CORDIC cells.
// ----------------------------------------------------------------------------
`default_nettype none
module haversine_distance #(
  parameter int CORDIC_STAGES = hvd_pkg::DefaultStages
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [22:0]  cfg_wdata,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // from_lat[27:0], from_lon[56:28], to_lat[84:57], to_lon[113:85]
  input  wire logic [119:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // distance_m[24:0]
  output logic [31:0]       m_axis_tdata
);
  import hvd_pkg::*;

  localparam int S = CORDIC_STAGES;
  localparam int Lat = S + 31 + S + 9;

  logic [RadW-1:0] radius;
  logic [Lat-1:0] vld;
  logic en;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) radius <= RadiusReset;
    else if (cfg_we) radius <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Lat-2:0], s_axis_tvalid};
  end
  assign m_axis_tvalid = vld[Lat-1];

  // Stage 0: differences and folding.
  logic signed [LatW-1:0] lat1, lat2;
  logic signed [LonW-1:0] lon1, lon2;
  assign lat1 = s_axis_tdata[27:0];
  assign lon1 = s_axis_tdata[56:28];
  assign lat2 = s_axis_tdata[84:57];
  assign lon2 = s_axis_tdata[113:85];

  logic [27:0] f_dlat, f_dlon, f_c1, f_c2;
  logic n_c1, n_c2;
  always_ff @(posedge clk) begin
    if (en) begin
      f_dlat <= fold_turn(30'(lat2) - 30'(lat1));
      f_dlon <= fold_turn(30'(lon2) - 30'(lon1));
      f_c1 <= fold_turn(30'(lat1));
      f_c2 <= fold_turn(30'(lat2));
    end
  end

  // Stage 1: quarter folding for cosines.
  logic [27:0] q_dlat, q_dlon, q_c1, q_c2;
  always_ff @(posedge clk) begin
    if (en) begin
      q_dlat <= f_dlat;
      q_dlon <= f_dlon;
      n_c1 <= f_c1 > QuarterTurn;
      n_c2 <= f_c2 > QuarterTurn;
      q_c1 <= (f_c1 > QuarterTurn) ? HalfTurn - f_c1 : f_c1;
      q_c2 <= (f_c2 > QuarterTurn) ? HalfTurn - f_c2 : f_c2;
    end
  end

  // Stage 2: radian conversion.
  logic [59:0] p_dlat, p_dlon, p_c1, p_c2;
  assign p_dlat = 60'(q_dlat) * 60'(UdegRadQ54) + (60'd1 << 24);
  assign p_dlon = 60'(q_dlon) * 60'(UdegRadQ54) + (60'd1 << 24);
  assign p_c1 = 60'(q_c1) * 60'(UdegRadQ54) + (60'd1 << 23);
  assign p_c2 = 60'(q_c2) * 60'(UdegRadQ54) + (60'd1 << 23);

  rot_t rin [4];
  logic [3:0] neg_in;
  always_ff @(posedge clk) begin
    if (en) begin
      rin[0] <= '{x: GainQ30, y: '0, z: $signed(AngW'(p_dlat >> 25))};
      rin[1] <= '{x: GainQ30, y: '0, z: $signed(AngW'(p_dlon >> 25))};
      rin[2] <= '{x: GainQ30, y: '0, z: $signed(AngW'(p_c1 >> 24))};
      rin[3] <= '{x: GainQ30, y: '0, z: $signed(AngW'(p_c2 >> 24))};
      neg_in <= {n_c2, n_c1, 2'b00};
    end
  end

  rot_t rc [4][S+1];
  logic [3:0] negd [S+1];
  assign negd[0] = neg_in;

  for (genvar k = 0; k < 4; k++) begin : g_lane
    assign rc[k][0] = rin[k];
    for (genvar i = 0; i < S; i++) begin : g_cell
      hvd_rot_cell #(.Idx(i)) u_cell (
        .clk (clk), .en (en), .din (rc[k][i]), .dout (rc[k][i+1])
      );
    end
  end
  for (genvar i = 0; i < S; i++) begin : g_neg
    always_ff @(posedge clk) begin
      if (en) negd[i+1] <= negd[i];
    end
  end

  // Products: two stages.
  logic signed [AngW-1:0] s1, s2, c1, c2;
  assign s1 = rc[0][S].y;
  assign s2 = rc[1][S].y;
  assign c1 = negd[S][2] ? -rc[2][S].x : rc[2][S].x;
  assign c2 = negd[S][3] ? -rc[3][S].x : rc[3][S].x;

  logic signed [67:0] m_s1s1;
  logic signed [31:0] m_cc, m_ss;
  always_ff @(posedge clk) begin
    if (en) begin
      m_s1s1 <= 68'(s1) * 68'(s1);
      m_cc <= 32'((68'(c1) * 68'(c2) + (68'sd1 <<< 29)) >>> 30);
      m_ss <= 32'((68'(s2) * 68'(s2) + (68'sd1 <<< 29)) >>> 30);
    end
  end

  logic signed [67:0] m_prod, m_sq;
  always_ff @(posedge clk) begin
    if (en) begin
      m_prod <= 68'(m_cc) * 68'(m_ss);
      m_sq <= m_s1s1;
    end
  end

  logic signed [67:0] a_sum;
  logic [60:0] a_cl;
  assign a_sum = m_sq + m_prod;
  always_ff @(posedge clk) begin
    if (en) begin
      if (a_sum < 0) a_cl <= '0;
      else if (a_sum > (68'sd1 <<< 60)) a_cl <= 61'd1 << 60;
      else a_cl <= a_sum[60:0];
    end
  end

  // Square roots: 31 digit cells each.
  root_t ra [32];
  root_t rb [32];
  assign ra[0] = '{rem: 62'(a_cl), res: '0, v: '0};
  assign rb[0] = '{rem: 62'((61'd1 << 60) - a_cl), res: '0, v: '0};
  for (genvar i = 0; i < 31; i++) begin : g_root
    hvd_root_cell #(.Idx(i)) u_ra (.clk(clk), .en(en), .din(ra[i]), .dout(ra[i+1]));
    hvd_root_cell #(.Idx(i)) u_rb (.clk(clk), .en(en), .din(rb[i]), .dout(rb[i+1]));
  end

  rot_t vc [S+1];
  assign vc[0] = '{x: $signed(AngW'(rb[31].res)), y: $signed(AngW'(ra[31].res)), z: '0};
  for (genvar i = 0; i < S; i++) begin : g_vec
    hvd_vec_cell #(.Idx(i)) u_vec (.clk(clk), .en(en), .din(vc[i]), .dout(vc[i+1]));
  end

  // Scale: z clamp and multiply.
  logic [31:0] zc;
  logic [63:0] dprod;
  always_ff @(posedge clk) begin
    if (en) begin
      zc <= (vc[S].z < 0) ? 32'd0 : 32'(vc[S].z);
      dprod <= 64'(radius) * 64'(zc);
    end
  end

  logic [63:0] dsum;
  assign dsum = ((dprod << 1) + (64'd1 << 29)) >> 30;
  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {7'd0, (dsum > 64'h1FFFFFF) ? 25'h1FFFFFF : dsum[24:0]};
    end
  end

  logic unused;
  assign unused = ^{s_axis_tdata[119:114], ra[31].rem, rb[31].rem, ra[31].v, rb[31].v,
                    rc[0][S].x, rc[0][S].z, rc[1][S].x, rc[1][S].z, rc[2][S].y,
                    rc[2][S].z, rc[3][S].y, rc[3][S].z, vc[S].x, vc[S].y, negd[S][1:0]};
endmodule
`default_nettype wire

[rtl/hvd_rot_cell.sv]
// ----------------------------------------------------------------------------
// hvd_rot_cell
// One rotation-mode CORDIC stage with registered output.
// ----------------------------------------------------------------------------
`default_nettype none
module hvd_rot_cell #(
  parameter int Idx = 0
) (
  input  wire logic      clk,
  input  wire logic      en,
  input  hvd_pkg::rot_t  din,
  output hvd_pkg::rot_t  dout
);
  import hvd_pkg::*;

  rot_t nxt;

  always_comb begin
    nxt = din;
    if (din.z >= 0) begin
      nxt.x = din.x - (din.y >>> Idx);
      nxt.y = din.y + (din.x >>> Idx);
      nxt.z = din.z - atan_q30(Idx);
    end else begin
      nxt.x = din.x + (din.y >>> Idx);
      nxt.y = din.y - (din.x >>> Idx);
      nxt.z = din.z + atan_q30(Idx);
    end
  end

  always_ff @(posedge clk) begin
    if (en) dout <= nxt;
  end
endmodule
`default_nettype wire

[rtl/hvd_vec_cell.sv]
// ----------------------------------------------------------------------------
// hvd_vec_cell
// One vectoring-mode CORDIC stage with registered output.
// ----------------------------------------------------------------------------
`default_nettype none
module hvd_vec_cell #(
  parameter int Idx = 0
) (
  input  wire logic      clk,
  input  wire logic      en,
  input  hvd_pkg::rot_t  din,
  output hvd_pkg::rot_t  dout
);
  import hvd_pkg::*;

  rot_t nxt;

  always_comb begin
    nxt = din;
    if (din.y >= 0) begin
      nxt.x = din.x + (din.y >>> Idx);
      nxt.y = din.y - (din.x >>> Idx);
      nxt.z = din.z + atan_q30(Idx);
    end else begin
      nxt.x = din.x - (din.y >>> Idx);
      nxt.y = din.y + (din.x >>> Idx);
      nxt.z = din.z - atan_q30(Idx);
    end
  end

  always_ff @(posedge clk) begin
    if (en) dout <= nxt;
  end
endmodule
`default_nettype wire

[rtl/hvd_root_cell.sv]
// ----------------------------------------------------------------------------
// hvd_root_cell
// One digit step of an exact integer square root, registered.
// ----------------------------------------------------------------------------
`default_nettype none
module hvd_root_cell #(
  parameter int Idx = 0
) (
  input  wire logic       clk,
  input  wire logic       en,
  input  hvd_pkg::root_t  din,
  output hvd_pkg::root_t  dout
);
  import hvd_pkg::*;

  localparam int Sh = 60 - 2 * Idx;

  root_t nxt;
  logic [61:0] trial;

  // rem: remainder, res: partial root shifted into place, bit position fixed.
  always_comb begin
    nxt = din;
    trial = din.res + (62'd1 << Sh);
    if (din.rem >= trial) begin
      nxt.rem = din.rem - trial;
      nxt.res = (din.res >> 1) + (62'd1 << Sh);
    end else begin
      nxt.res = din.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) dout <= nxt;
  end
endmodule
`default_nettype wire

[rtl/hvd_checker.sv]
// ----------------------------------------------------------------------------
// hvd_checker
// Port-level checks for the haversine distance block.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module hvd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);
  `CHK_ASSERT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "payload changed")
  `CHK_ASSERT(a_range, clk, rst, m_axis_tvalid |-> m_axis_tdata[31:25] == 7'd0, "pad bits set")
  `CHK_ASSERT(a_ready, clk, rst, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "ready wrong")
  `CHK_ASSERT_ALWAYS(a_rst, clk, $past(rst) |-> !m_axis_tvalid, "valid after reset")
endmodule

bind haversine_distance hvd_checker u_hvd_checker (
  .clk (clk), .rst (rst), .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid), .m_axis_tready (m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for haversine_distance: a directed table and random
// position pairs are streamed in under several idle patterns and radii;
// every distance is compared against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module tb;

  localparam int Stages = hvd_pkg::DefaultStages;
  localparam int Latency = 2 * Stages + 40;
  localparam int CycleLimit = 600000;
  localparam int PhaseItems = 150;
  localparam int NumPhases = 8;
  localparam longint FullTurnU = 360000000;
  localparam longint HalfTurnU = 180000000;
  localparam longint QuarterTurnU = 90000000;
  localparam longint unsigned PiQ60 = 64'h3243F6A8885A308D;
  localparam longint unsigned RadK = ((PiQ60 >> 6) + 64'd90000000) / 64'd180000000;
  localparam longint GainStart = 652032874;
  localparam longint OneQ60 = 64'sd1 << 60;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct {
    logic [27:0] from_lat;
    logic [28:0] from_lon;
    logic [27:0] to_lat;
    logic [28:0] to_lon;
  } pair_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [22:0]  cfg_wdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [31:0]  m_axis_tdata;

  haversine_distance dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [24:0]    pending_dist[$];
  longint unsigned radius_m = 64'd6371000;
  idle_mode_e     idle_mode = IDLE_NONE;
  int             hold_off = 0;
  int             mismatches = 0;
  int             dist_seen = 0;
  int             pairs_sent = 0;
  int             cycles = 0;

  function automatic longint atan_step(input int i);
    longint tab[32] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                        33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
                        524288, 262144, 131072, 65536, 32768, 16384, 8192, 4096,
                        2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0};
    return tab[i];
  endfunction

  function automatic longint fold_udeg(input longint d);
    longint r;
    r = d % FullTurnU;
    if (r < 0) r += FullTurnU;
    if (r > HalfTurnU) r = FullTurnU - r;
    return r;
  endfunction

  function automatic longint udeg_rad(input longint r, input int sh);
    longint unsigned p;
    p = longint'(unsigned'(r)) * RadK + (64'd1 << (sh - 1));
    return longint'(p >> sh);
  endfunction

  function automatic void cordic_rotate(input longint z0, output longint c,
                                        output longint s);
    longint x, y, z, dx, dy;
    x = GainStart;
    y = 0;
    z = z0;
    for (int i = 0; i < Stages && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint cordic_angle(input longint x0, input longint y0);
    longint x, y, z, dx, dy;
    x = x0;
    y = y0;
    z = 0;
    for (int i = 0; i < Stages && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_step(i);
      end else begin
        x -= dx; y += dy; z -= atan_step(i);
      end
    end
    return z;
  endfunction

  function automatic longint int_root(input longint unsigned v0);
    longint unsigned v, res, b;
    v = v0;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint half_sin(input longint d);
    longint c, s;
    cordic_rotate(udeg_rad(fold_udeg(d), 25), c, s);
    return s;
  endfunction

  function automatic longint lat_cos(input longint lat);
    longint r, c, s;
    logic neg;
    r = fold_udeg(lat);
    neg = r > QuarterTurnU;
    if (neg) r = HalfTurnU - r;
    cordic_rotate(udeg_rad(r, 24), c, s);
    return neg ? -c : c;
  endfunction

  function automatic logic [24:0] predict_distance(input pair_t p);
    longint lat1, lon1, lat2, lon2, s1, s2, c1, c2, cc, ss, a, z;
    longint unsigned dist_m;
    lat1 = longint'($signed(p.from_lat));
    lon1 = longint'($signed(p.from_lon));
    lat2 = longint'($signed(p.to_lat));
    lon2 = longint'($signed(p.to_lon));
    s1 = half_sin(lat2 - lat1);
    s2 = half_sin(lon2 - lon1);
    c1 = lat_cos(lat1);
    c2 = lat_cos(lat2);
    cc = (c1 * c2 + (64'sd1 << 29)) >>> 30;
    ss = (s2 * s2 + (64'sd1 << 29)) >>> 30;
    a = s1 * s1 + cc * ss;
    if (a < 0) a = 0;
    if (a > OneQ60) a = OneQ60;
    z = cordic_angle(int_root(longint'(OneQ60 - a)), int_root(a));
    if (z < 0) z = 0;
    dist_m = (64'd2 * radius_m * longint'(unsigned'(z)) + (64'd1 << 29)) >> 30;
    if (dist_m > 64'd33554431) dist_m = 64'd33554431;
    return dist_m[24:0];
  endfunction

  function automatic pair_t mk_pair(input longint a, input longint b,
                                    input longint c, input longint d);
    pair_t p;
    p.from_lat = a[27:0];
    p.from_lon = b[28:0];
    p.to_lat = c[27:0];
    p.to_lon = d[28:0];
    return p;
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      p.from_lat = 28'($urandom);
      p.from_lon = 29'($urandom);
      p.to_lat = 28'($urandom);
      p.to_lon = 29'($urandom);
    end else begin
      p = mk_pair(longint'($urandom_range(180000000)) - QuarterTurnU,
                  longint'($urandom_range(360000000)) - HalfTurnU,
                  longint'($urandom_range(180000000)) - QuarterTurnU,
                  longint'($urandom_range(360000000)) - HalfTurnU);
      if (pick < 40) begin
        p.to_lat = p.from_lat + 28'(longint'($urandom_range(2000)) - 1000);
        p.to_lon = p.from_lon + 29'(longint'($urandom_range(2000)) - 1000);
      end
    end
    return p;
  endfunction

  // from_lat[27:0], from_lon[56:28], to_lat[84:57], to_lon[113:85]
  task automatic send_pair(input pair_t p);
    s_axis_tdata <= {6'd0, p.to_lon, p.to_lat, p.from_lon, p.from_lat};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    pending_dist.push_back(predict_distance(p));
    pairs_sent++;
    if (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) begin
      if ($urandom_range(99) < (idle_mode == IDLE_SEND ? 62 : 11)) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while ($urandom_range(99) < 50);
      end
    end
  endtask

  task automatic drain_and_write(input logic [22:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_dist.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    radius_m = 64'(value);
  endtask

  always @(posedge clk) begin
    logic [24:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      dist_seen++;
      if (pending_dist.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected distance %0d", m_axis_tdata[24:0]);
      end else begin
        want = pending_dist.pop_front();
        if (m_axis_tdata[24:0] !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("distance mismatch: expected %0d, got %0d", want, m_axis_tdata[24:0]);
        end
      end
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_mode == IDLE_RECV) begin
      m_axis_tready <= $urandom_range(99) >= 62;
    end else if (idle_mode == IDLE_BOTH) begin
      m_axis_tready <= $urandom_range(99) >= 11;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    pair_t table_rows[$];
    logic [22:0] radii[NumPhases] = '{23'd6371000, 23'd6300000, 23'd6400000, 23'd0,
                                      23'd8388607, 23'd1, 23'd6371000, 23'd4194304};
    table_rows.push_back(mk_pair(0, 0, 0, 0));
    table_rows.push_back(mk_pair(0, 0, 0, 180000000));
    table_rows.push_back(mk_pair(0, -180000000, 0, 180000000));
    table_rows.push_back(mk_pair(90000000, 0, -90000000, 0));
    table_rows.push_back(mk_pair(90000000, 45000000, 90000000, -135000000));
    table_rows.push_back(mk_pair(-90000000, -180000000, 90000000, 180000000));
    table_rows.push_back(mk_pair(45000000, 10000000, 45000001, 10000001));
    table_rows.push_back(mk_pair(-134217728, -268435456, 134217727, 268435455));
    table_rows.push_back(mk_pair(134217727, 268435455, -134217728, -268435456));
    table_rows.push_back(mk_pair(100000000, 0, 80000000, 0));
    table_rows.push_back(mk_pair(-100000000, 200000000, 30000000, -200000000));
    table_rows.push_back(mk_pair(0, 0, 0, 90000000));
    table_rows.push_back(mk_pair(0, 0, 1, 0));
    table_rows.push_back(mk_pair(51500000, -100000, 40700000, -74000000));
    table_rows.push_back(mk_pair(-33900000, 151200000, 35700000, 139700000));
    table_rows.push_back(mk_pair(0, 0, 0, 179999999));
    table_rows.push_back(mk_pair(0, 0, 0, -180000001));
    table_rows.push_back(mk_pair(89999999, 0, -89999999, 180000000));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (table_rows[i]) send_pair(table_rows[i]);

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_and_write(radii[ph]);
      idle_mode = idle_mode_e'(ph % 4);
      if (ph == 0) hold_off = 400;
      for (int n = 0; n < PhaseItems; n++) send_pair(random_pair());
    end

    s_axis_tvalid <= 1'b0;
    while (pending_dist.size() != 0) @(posedge clk);
    repeat (Latency + 20) @(posedge clk);
    $display("sent %0d position pairs over %0d radius settings and four idle patterns",
             pairs_sent, NumPhases + 1);
    $display("checked %0d distances, %0d mismatches", dist_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
